[src/drop_pkg.sv]
// Shared types and constants for the DHCP reply option parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package drop_pkg;

  // sizes of the port groups
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 200;
  localparam int OUT_TUSER_W = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXPECTED_XID = 1'b0,
    CFG_AREA_LIMIT   = 1'b1
  } cfg_reg_t;

  localparam logic [9:0] LIMIT_RESET = 10'd500;
  localparam logic [9:0] COOKIE_LAST = 10'd3;
  localparam logic [9:0] OFFSET_MAX  = 10'd1023;

  // header and option codes
  localparam logic [7:0] OP_REPLY     = 8'h02;
  localparam logic [7:0] OPT_PAD      = 8'h00;
  localparam logic [7:0] OPT_END      = 8'hff;
  localparam logic [7:0] OPT_MSG_TYPE = 8'h35;
  localparam logic [7:0] OPT_SERVER   = 8'h36;
  localparam logic [7:0] OPT_ROUTER   = 8'h03;
  localparam logic [7:0] OPT_DNS      = 8'h06;
  localparam logic [7:0] OPT_LEASE    = 8'h33;
  localparam logic [7:0] TYPE_OFFER   = 8'h02;
  localparam logic [7:0] TYPE_ACK     = 8'h05;

  // value bytes kept per option
  localparam logic [2:0] VALUE_KEEP = 3'd4;

  typedef enum logic [2:0] {
    PH_COOKIE = 3'd0,
    PH_CODE   = 3'd1,
    PH_LEN    = 3'd2,
    PH_VALUE  = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    OC_NOT_OURS = 2'd0,
    OC_OFFER    = 2'd1,
    OC_ACK      = 2'd2,
    OC_OTHER    = 2'd3
  } outcome_t;

  // one classified byte as it waits in the queue
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first;
    logic        last;
    logic        match;
    logic [31:0] offered;
  } q_entry_t;

  // replace one byte of a big-endian word, index 0 is the top byte
  function automatic logic [31:0] set_byte(input logic [31:0] word,
                                           input logic [1:0]  idx,
                                           input logic [7:0]  b);
    logic [31:0] w;
    w = word;
    case (idx)
      2'd0:    w[31:24] = b;
      2'd1:    w[23:16] = b;
      2'd2:    w[15:8]  = b;
      default: w[7:0]   = b;
    endcase
    return w;
  endfunction

endpackage

[src/drop_queue.sv]
// Small flop queue between the classifying front and the parsing back.
// Depends on drop_pkg for the entry type.
`timescale 1ns / 1ps

module drop_queue
  import drop_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     full,
  input  logic     pop,
  output q_entry_t pop_entry,
  output logic     not_empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  q_entry_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_FULL);
  assign not_empty = (count_r != '0);
  assign pop_entry = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

[src/drop_front.sv]
// Front end: configuration registers, input beat acceptance, header match.
// Depends on drop_pkg; feeds drop_queue.
`timescale 1ns / 1ps

module drop_front
  import drop_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tuser,
  input  logic                  in_tlast,
  // queue side
  output logic                  q_push,
  output q_entry_t              q_entry,
  input  logic                  q_full,
  output logic [9:0]            area_limit
);

  logic [31:0] expected_xid_r, expected_xid_nxt;
  logic [9:0]  area_limit_r, area_limit_nxt;

  assign cfg_ready  = 1'b1;
  assign area_limit = area_limit_r;

  // register writes
  always_comb begin
    expected_xid_nxt = expected_xid_r;
    area_limit_nxt   = area_limit_r;
    if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_EXPECTED_XID: expected_xid_nxt = cfg_data;
        CFG_AREA_LIMIT:   area_limit_nxt   = cfg_data[9:0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_xid_r <= '0;
      area_limit_r   <= LIMIT_RESET;
    end else begin
      expected_xid_r <= expected_xid_nxt;
      area_limit_r   <= area_limit_nxt;
    end
  end

  // accept a beat whenever the queue has room
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // classify: header of this message is ours
  always_comb begin
    q_entry.data_byte = in_tdata[7:0];
    q_entry.first     = in_tuser;
    q_entry.last      = in_tlast;
    q_entry.match     = (in_tdata[39:8] == expected_xid_r) && (in_tdata[47:40] == OP_REPLY);
    q_entry.offered   = in_tdata[79:48];
  end

endmodule

[src/drop_back.sv]
// Back end: option walk over queued bytes and the result output register.
// Depends on drop_pkg; drains drop_queue.
`timescale 1ns / 1ps

module drop_back
  import drop_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  q_entry_t               q_entry,
  output logic                   q_pop,
  input  logic [9:0]             area_limit,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [OUT_TUSER_W-1:0] out_tuser
);

  phase_t      phase_r, phase_nxt, phase_eff;
  logic [9:0]  off_r, off_nxt, off_eff;
  logic [7:0]  code_r, code_nxt, code_eff;
  logic [7:0]  left_r, left_nxt, left_eff, left_dec;
  logic [2:0]  vidx_r, vidx_nxt, vidx_eff;
  logic        hm_r, hm_nxt, hm_eff;
  logic [7:0]  kind_r, kind_nxt, kind_eff;
  logic [31:0] server_r, server_nxt, server_eff;
  logic [31:0] router_r, router_nxt, router_eff;
  logic [31:0] dns_r, dns_nxt, dns_eff;
  logic [31:0] lease_r, lease_nxt, lease_eff;
  logic [31:0] offered_r, offered_nxt;
  logic        ovr_r, ovr_nxt, ovr_eff;
  logic        len_over;
  logic [7:0]  b;

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic [OUT_TUSER_W-1:0] out_user_r, out_user_nxt;
  outcome_t               oc;

  assign b = q_entry.data_byte;

  // a last beat needs room in the output register
  assign q_pop = q_valid && (!q_entry.last || !out_valid_r || out_tready);

  // state as seen by this beat: a first beat restarts the message
  always_comb begin
    hm_eff     = q_entry.first ? q_entry.match : hm_r;
    phase_eff  = q_entry.first ? PH_COOKIE : phase_r;
    off_eff    = q_entry.first ? '0 : off_r;
    code_eff   = q_entry.first ? '0 : code_r;
    left_eff   = q_entry.first ? '0 : left_r;
    vidx_eff   = q_entry.first ? '0 : vidx_r;
    kind_eff   = q_entry.first ? '0 : kind_r;
    server_eff = q_entry.first ? '0 : server_r;
    router_eff = q_entry.first ? '0 : router_r;
    dns_eff    = q_entry.first ? '0 : dns_r;
    lease_eff  = q_entry.first ? '0 : lease_r;
    ovr_eff    = q_entry.first ? 1'b0 : ovr_r;
    offered_nxt = q_entry.first ? q_entry.offered : offered_r;
    left_dec   = left_eff - 8'd1;
    len_over   = ({1'b0, off_eff} + 11'd1 + {3'b000, b}) > {1'b0, area_limit};
  end

  // parse phase transitions
  always_comb begin
    phase_nxt = phase_eff;
    if (hm_eff) begin
      case (phase_eff)
        PH_COOKIE: if (off_eff >= COOKIE_LAST) phase_nxt = PH_CODE;
        PH_CODE: begin
          if (b == OPT_END) begin
            phase_nxt = PH_DONE;
          end else if (b != OPT_PAD) begin
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          if (len_over) begin
            phase_nxt = PH_DONE;
          end else begin
            phase_nxt = (b == 8'd0) ? PH_CODE : PH_VALUE;
          end
        end
        PH_VALUE: if (left_dec == 8'd0) phase_nxt = PH_CODE;
        default:  ;
      endcase
    end
    if (q_entry.last) begin
      phase_nxt = PH_DONE;
    end
  end

  // counters and kept option values
  always_comb begin
    off_nxt    = off_eff;
    code_nxt   = code_eff;
    left_nxt   = left_eff;
    vidx_nxt   = vidx_eff;
    kind_nxt   = kind_eff;
    server_nxt = server_eff;
    router_nxt = router_eff;
    dns_nxt    = dns_eff;
    lease_nxt  = lease_eff;
    ovr_nxt    = ovr_eff;
    hm_nxt     = q_entry.last ? 1'b0 : hm_eff;
    if (hm_eff) begin
      if (off_eff != OFFSET_MAX) begin
        off_nxt = off_eff + 10'd1;
      end
      case (phase_eff)
        PH_CODE: begin
          if (b != OPT_END && b != OPT_PAD) code_nxt = b;
        end
        PH_LEN: begin
          if (len_over) begin
            ovr_nxt = 1'b1;
          end else begin
            // option accepted: clear its target before the value arrives
            left_nxt = b;
            vidx_nxt = '0;
            case (code_eff)
              OPT_MSG_TYPE: kind_nxt   = '0;
              OPT_SERVER:   server_nxt = '0;
              OPT_ROUTER:   router_nxt = '0;
              OPT_DNS:      dns_nxt    = '0;
              OPT_LEASE:    lease_nxt  = '0;
              default:      ;
            endcase
          end
        end
        PH_VALUE: begin
          left_nxt = left_dec;
          if (vidx_eff < VALUE_KEEP) begin
            vidx_nxt = vidx_eff + 3'd1;
            case (code_eff)
              OPT_MSG_TYPE: if (vidx_eff == 3'd0) kind_nxt = b;
              OPT_SERVER:   server_nxt = set_byte(server_eff, vidx_eff[1:0], b);
              OPT_ROUTER:   router_nxt = set_byte(router_eff, vidx_eff[1:0], b);
              OPT_DNS:      dns_nxt    = set_byte(dns_eff, vidx_eff[1:0], b);
              OPT_LEASE:    lease_nxt  = set_byte(lease_eff, vidx_eff[1:0], b);
              default:      ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_COOKIE;
      off_r     <= '0;
      code_r    <= '0;
      left_r    <= '0;
      vidx_r    <= '0;
      hm_r      <= 1'b0;
      kind_r    <= '0;
      server_r  <= '0;
      router_r  <= '0;
      dns_r     <= '0;
      lease_r   <= '0;
      offered_r <= '0;
      ovr_r     <= 1'b0;
    end else if (q_pop) begin
      phase_r   <= phase_nxt;
      off_r     <= off_nxt;
      code_r    <= code_nxt;
      left_r    <= left_nxt;
      vidx_r    <= vidx_nxt;
      hm_r      <= hm_nxt;
      kind_r    <= kind_nxt;
      server_r  <= server_nxt;
      router_r  <= router_nxt;
      dns_r     <= dns_nxt;
      lease_r   <= lease_nxt;
      offered_r <= offered_nxt;
      ovr_r     <= ovr_nxt;
    end
  end

  // result beat, all zero when the message is not ours
  always_comb begin
    if (!hm_eff) begin
      oc = OC_NOT_OURS;
    end else if (kind_nxt == TYPE_OFFER) begin
      oc = OC_OFFER;
    end else if (kind_nxt == TYPE_ACK) begin
      oc = OC_ACK;
    end else begin
      oc = OC_OTHER;
    end
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    if (q_pop && q_entry.last) begin
      out_valid_nxt = 1'b1;
      if (hm_eff) begin
        out_data_nxt = {1'b0, lease_nxt[31:1], lease_nxt, dns_nxt, router_nxt,
                        server_nxt, offered_nxt, kind_nxt};
        out_user_nxt = {ovr_nxt, oc};
      end else begin
        out_data_nxt = '0;
        out_user_nxt = {1'b0, oc};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

[src/dhcp_reply_option_parser.sv]
// Top level of the DHCP reply option parser: front, queue and back.
// Depends on drop_pkg, drop_front, drop_queue and drop_back.
//
// channel  direction  handshake              payload
// cfg      in         cfg_valid/cfg_ready    cfg_index, cfg_data
// in       in         in_tvalid/in_tready    in_tdata, in_tuser, in_tlast
// out      out        out_tvalid/out_tready  out_tdata, out_tuser
//
// One options byte per cycle is sustained while the output does not stall;
// the back end updates the parse state once per byte. A result appears in
// the output register the cycle after its last byte leaves the queue. Reset
// (rst_n low, synchronous) restores the control registers and empties the
// queue; queue storage and output data are not reset. A stalled output holds
// a last byte at the head of the queue, and the input stalls once it is full.
`timescale 1ns / 1ps

module dhcp_reply_option_parser
  import drop_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // data_byte[7:0], header_xid[39:8], header_op[47:40], offered_address[79:48]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // first_byte
  input  logic                   in_tuser,
  // last_byte
  input  logic                   in_tlast,
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // msg_kind[7:0], your_address[39:8], server_id[71:40], router_address[103:72],
  // dns_address[135:104], lease_seconds[167:136], renew_seconds[198:168], zero[199]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // outcome[1:0], truncated[2]
  output logic [OUT_TUSER_W-1:0] out_tuser
);

  logic       q_push, q_full, q_pop, q_valid;
  q_entry_t   push_entry, pop_entry;
  logic [9:0] area_limit;

  drop_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .q_push     (q_push),
    .q_entry    (push_entry),
    .q_full     (q_full),
    .area_limit (area_limit)
  );

  drop_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .not_empty  (q_valid)
  );

  drop_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_entry    (pop_entry),
    .q_pop      (q_pop),
    .area_limit (area_limit),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
